// ----- rtl/olidd_pkg.sv -----
// Shared types, widths and codes for the ordered list block.
package olidd_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned POS_W     = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_REMOVE     = 2'd2
  } action_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] element;
    logic                    last;
    logic                    empty_res;
    logic                    dropped;
  } res_t;

endpackage

// ----- rtl/olidd_if.sv -----
// Valid/ready channel interfaces for command items and dump items.
interface olidd_in_if import olidd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [VAL_W-1:0] value;
  logic [POS_W-1:0]        position;

  modport source (output valid, action, value, position, input ready);
  modport sink   (input valid, action, value, position, output ready);
endinterface

interface olidd_out_if import olidd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] element;
  logic                    last;
  logic                    empty_res;
  logic                    dropped;

  modport source (output valid, element, last, empty_res, dropped, input ready);
  modport sink   (input valid, element, last, empty_res, dropped, output ready);
endinterface

// ----- rtl/ordered_list_insert_delete_dump_core.sv -----
// Ordered list: insert at front, append at back, remove at index, dump after each item.
//
// Channels: in_ch carries one command item (action, value, position); out_ch
// returns the whole list front to back, one item per element, last marked.
// An empty list dumps a single item with empty_res set and element zero.
// dropped is set on every dump item of an insert refused on a full list.
// Both channels complete a transfer when valid and ready are high at a clock edge.
//
// Timing: in_ch.ready is high only while no command is being worked on.
// After an accepted command the first dump item is read from the RAM in ST_DUMP
// and registered into the output queue; an empty list dumps without a RAM read.
// A removal at index p past the front first moves the n-p-1 entries behind
// it in ST_SHIFT, one RAM read and one RAM write per cycle. The dump then
// reads one element per cycle from the RAM while the output queue has room.
// The dump feeds a two-entry output queue; when out_ch stalls, RAM reads stop
// and resume without loss. The next command is taken while the last dump
// items still wait in the queue.
// Reset (rst_n low, synchronous) empties the list and the output queue; the
// RAM contents are not cleared, only entries written since are read.
module ordered_list_insert_delete_dump_core import olidd_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  olidd_in_if.sink    in_ch,
  olidd_out_if.source out_ch
);

  localparam int unsigned SLOT_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SHIFT = 3'b010,
    ST_DUMP  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [SLOT_W-1:0]  front_r, front_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               dropped_r, dropped_nxt;
  logic [SLOT_W-1:0]  wslot_r, wslot_nxt;
  logic               wpend_r, wpend_nxt;
  logic               inflight_r, inflight_nxt;
  logic               inflight_last_r, inflight_last_nxt;
  logic               q_head_r, q_head_nxt;
  logic [1:0]         q_cnt_r, q_cnt_nxt;
  res_t               q_r [2];

  logic               ram_we, ram_re;
  logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
  logic [VAL_W-1:0]   ram_wdata, ram_rdata;

  logic               in_acc, pop, room, full, push_v;
  logic [2:0]         occ_after;
  res_t               push_d;
  logic [SLOT_W-1:0]  front_dec, front_inc;
  logic [CNT_W-1:0]   idx_m1;

  // ring slot of list index idx (idx below DEPTH)
  function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] front,
                                                input logic [CNT_W-1:0]  idx);
    logic [SLOT_W:0] s;
    s = {1'b0, front} + (SLOT_W+1)'(idx);
    if (s >= (SLOT_W+1)'(DEPTH)) begin
      s = s - (SLOT_W+1)'(DEPTH);
    end
    return s[SLOT_W-1:0];
  endfunction

  olidd_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign out_ch.valid     = (q_cnt_r != 2'd0);
  assign out_ch.element   = q_r[q_head_r].element;
  assign out_ch.last      = q_r[q_head_r].last;
  assign out_ch.empty_res = q_r[q_head_r].empty_res;
  assign out_ch.dropped   = q_r[q_head_r].dropped;
  assign pop              = out_ch.valid && out_ch.ready;

  // a read issued now lands next cycle; keep the queue from overflowing
  assign occ_after = {1'b0, q_cnt_r} + {2'b00, inflight_r} - {2'b00, pop};
  assign room      = (occ_after <= 3'd1);

  assign full      = (count_r == CNT_W'(DEPTH));
  assign front_dec = (front_r == '0) ? SLOT_W'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == SLOT_W'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign idx_m1    = idx_r - 1'b1;

  always_comb begin
    state_nxt         = state_r;
    front_nxt         = front_r;
    count_nxt         = count_r;
    idx_nxt           = idx_r;
    dropped_nxt       = dropped_r;
    wslot_nxt         = wslot_r;
    wpend_nxt         = 1'b0;
    inflight_nxt      = 1'b0;
    inflight_last_nxt = inflight_last_r;
    ram_we            = 1'b0;
    ram_waddr         = front_dec;
    ram_wdata         = in_ch.value;
    ram_re            = 1'b0;
    ram_raddr         = slot_of(front_r, idx_r);
    push_v            = inflight_r;
    push_d            = '{element: ram_rdata, last: inflight_last_r,
                          empty_res: 1'b0, dropped: dropped_r};

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          dropped_nxt = 1'b0;
          idx_nxt     = '0;
          state_nxt   = ST_DUMP;
          case (in_ch.action)
            ACT_PUSH_FRONT: begin
              if (full) begin
                dropped_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = front_dec;
                front_nxt = front_dec;
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_PUSH_BACK: begin
              if (full) begin
                dropped_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = slot_of(front_r, count_r);
                count_nxt = count_r + 1'b1;
              end
            end
            ACT_REMOVE: begin
              if (in_ch.position < POS_W'(count_r)) begin
                count_nxt = count_r - 1'b1;
                if (in_ch.position == '0) begin
                  front_nxt = (count_r == CNT_W'(1)) ? '0 : front_inc;
                end else if (in_ch.position < POS_W'(count_r - 1'b1)) begin
                  // entries behind the removed one move up by one slot
                  idx_nxt   = CNT_W'(in_ch.position) + 1'b1;
                  state_nxt = ST_SHIFT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // idx_r is the source index; its data is written one slot forward next cycle
        if (wpend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wslot_r;
          ram_wdata = ram_rdata;
        end
        if (idx_r <= count_r) begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(front_r, idx_r);
          wslot_nxt = slot_of(front_r, idx_m1);
          wpend_nxt = 1'b1;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          idx_nxt   = '0;
          state_nxt = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (count_r == '0) begin
          if (!inflight_r && room) begin
            push_v    = 1'b1;
            push_d    = '{element: '0, last: 1'b1, empty_res: 1'b1,
                          dropped: dropped_r};
            state_nxt = ST_IDLE;
          end
        end else if (room) begin
          ram_re            = 1'b1;
          ram_raddr         = slot_of(front_r, idx_r);
          inflight_nxt      = 1'b1;
          inflight_last_nxt = (idx_r == count_r - 1'b1);
          idx_nxt           = idx_r + 1'b1;
          if (idx_r == count_r - 1'b1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    q_head_nxt = pop ? ~q_head_r : q_head_r;
    q_cnt_nxt  = q_cnt_r + {1'b0, push_v} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      front_r    <= '0;
      count_r    <= '0;
      idx_r      <= '0;
      dropped_r  <= 1'b0;
      wpend_r    <= 1'b0;
      inflight_r <= 1'b0;
      q_head_r   <= 1'b0;
      q_cnt_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      front_r    <= front_nxt;
      count_r    <= count_nxt;
      idx_r      <= idx_nxt;
      dropped_r  <= dropped_nxt;
      wpend_r    <= wpend_nxt;
      inflight_r <= inflight_nxt;
      q_head_r   <= q_head_nxt;
      q_cnt_r    <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wslot_r         <= wslot_nxt;
    inflight_last_r <= inflight_last_nxt;
    if (push_v) begin
      q_r[q_head_r ^ q_cnt_r[0]] <= push_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list count above depth");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= 2'd2)
    else $error("output queue count above two");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r |-> !(q_cnt_r == 2'd2 && !pop))
    else $error("read data arrives at a full output queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE)
    else $error("accepted item did not start work");

  a_wpend_shift: assert property (@(posedge clk) disable iff (!rst_n)
    wpend_r |-> state_r == ST_SHIFT)
    else $error("pending move write outside shift");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.empty_res |-> out_ch.last)
    else $error("empty dump item not marked last");
`endif

endmodule

// ----- rtl/olidd_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module olidd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/sv/ordered_list_insert_delete_dump_core_test.sv -----
// Testbench for the ordered list core: directed and random command items, dump items checked against a list model.
module ordered_list_insert_delete_dump_core_test;
  import olidd_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 4 * DEPTH + 16;

  localparam logic [ACT_W-1:0]        ACT_NONE = 2'd3;  // not decoded, list only dumped
  localparam logic signed [VAL_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN  = 32'sh8000_0000;
  localparam logic [POS_W-1:0]        POS_MAX  = '1;

  // Holds the list as the block should hold it and the dump items still owed.
  class list_dump_board;
    logic signed [VAL_W-1:0] held[$];
    res_t                    owed[$];
    int unsigned             depth;
    int unsigned             failures;

    function new(int unsigned d);
      depth    = d;
      failures = 0;
    endfunction

    function int unsigned count();
      return held.size();
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    function void note_command(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos);
      logic refused;
      res_t r;
      refused = 1'b0;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (held.size() >= depth) refused = 1'b1;
          else if (act == ACT_PUSH_FRONT) held.push_front(val);
          else held.push_back(val);
        end
        ACT_REMOVE: begin
          if (int'(pos) < held.size()) held.delete(int'(pos));
        end
        default: ;
      endcase
      if (held.size() == 0) begin
        r.element   = '0;
        r.last      = 1'b1;
        r.empty_res = 1'b1;
        r.dropped   = refused;
        owed.push_back(r);
      end else begin
        foreach (held[i]) begin
          r.element   = held[i];
          r.last      = (i == held.size() - 1);
          r.empty_res = 1'b0;
          r.dropped   = refused;
          owed.push_back(r);
        end
      end
    endfunction

    function void check_item(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $error("dump item with nothing owed: element %0d last %0b", got.element, got.last);
        failures++;
        return;
      end
      want = owed.pop_front();
      if (got.element !== want.element) begin
        $error("element mismatch: expected %0d, got %0d", want.element, got.element);
        failures++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, got %0b", want.last, got.last);
        failures++;
      end
      if (got.empty_res !== want.empty_res) begin
        $error("empty_res mismatch: expected %0b, got %0b", want.empty_res, got.empty_res);
        failures++;
      end
      if (got.dropped !== want.dropped) begin
        $error("dropped mismatch: expected %0b, got %0b", want.dropped, got.dropped);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int unsigned cycles = 0;
  list_dump_board board;

  olidd_in_if  in_if ();
  olidd_out_if out_if ();

  ordered_list_insert_delete_dump_core #(.DEPTH(DEPTH)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_cmd(input logic [ACT_W-1:0] act, input logic signed [VAL_W-1:0] val,
                          input logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.action   <= act;
    in_if.value    <= val;
    in_if.position <= pos;
    do @(posedge clk); while (!in_if.ready);
    board.note_command(act, val, pos);
    @(negedge clk);
  endtask

  task automatic take_dumps();
    int unsigned gap;
    res_t got;
    forever begin
      gap = draw_gap();
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      got.element   = out_if.element;
      got.last      = out_if.last;
      got.empty_res = out_if.empty_res;
      got.dropped   = out_if.dropped;
      board.check_item(got);
      @(negedge clk);
    end
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // Mostly in range, with the ends of the list and out-of-range indexes mixed in.
  function automatic logic [POS_W-1:0] pick_position();
    int unsigned n;
    n = board.count();
    if (n == 0) return POS_W'($urandom_range(0, 65535));
    case ($urandom_range(0, 9))
      0:       return POS_W'($urandom_range(n, 65535));
      1:       return '0;
      2:       return POS_W'(n - 1);
      3:       return POS_MAX;
      default: return POS_W'($urandom_range(0, n - 1));
    endcase
  endfunction

  task automatic run_mix(input int unsigned n_items, input int unsigned pct_ins,
                         input int unsigned pct_rem);
    int unsigned r;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < pct_ins)
        send_cmd($urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT, pick_value(),
                 POS_W'($urandom_range(0, 65535)));
      else if (r < pct_ins + pct_rem)
        send_cmd(ACT_REMOVE, $urandom(), pick_position());
      else
        send_cmd(ACT_NONE, $urandom(), POS_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin : main_seq
    board          = new(DEPTH);
    calm           = 1'b0;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.action   = ACT_PUSH_FRONT;
    in_if.value    = '0;
    in_if.position = '0;
    out_if.ready   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    fork
      take_dumps();
    join_none

    // directed: empty list, extremes, each end and the middle, out-of-range removes
    send_cmd(ACT_NONE, '0, '0);
    send_cmd(ACT_REMOVE, '0, '0);
    send_cmd(ACT_REMOVE, '0, POS_MAX);
    send_cmd(ACT_PUSH_BACK, VAL_MAX, '0);
    send_cmd(ACT_PUSH_FRONT, VAL_MIN, POS_MAX);
    send_cmd(ACT_PUSH_BACK, '0, '0);
    send_cmd(ACT_PUSH_FRONT, -32'sd1, '0);
    send_cmd(ACT_PUSH_BACK, 32'sh5555_5555, 16'h5555);
    send_cmd(ACT_PUSH_FRONT, 32'shAAAA_AAAA, 16'hAAAA);
    send_cmd(ACT_REMOVE, '0, 16'd2);
    send_cmd(ACT_REMOVE, '0, POS_W'(board.count() - 1));
    send_cmd(ACT_REMOVE, '0, POS_W'(board.count()));
    send_cmd(ACT_REMOVE, '1, POS_MAX);
    send_cmd(ACT_NONE, '1, POS_MAX);
    calm = 1'b1;
    send_cmd(ACT_REMOVE, '0, '0);
    send_cmd(ACT_REMOVE, '0, '0);
    send_cmd(ACT_REMOVE, '0, '0);
    send_cmd(ACT_REMOVE, '0, '0);
    send_cmd(ACT_PUSH_FRONT, 32'sd1, '0);
    send_cmd(ACT_REMOVE, '0, '0);
    send_cmd(ACT_PUSH_BACK, 32'sd2, '0);
    send_cmd(ACT_REMOVE, '0, 16'd1);
    calm = 1'b0;

    // random: mixed, fill past full, drain past empty, mixed without idling
    run_mix(40, 50, 42);
    calm = 1'b1;
    run_mix(30, 92, 6);
    calm = 1'b0;
    run_mix(60, 92, 6);
    run_mix(80, 10, 85);
    calm = 1'b1;
    run_mix(20, 45, 45);
    in_if.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (board.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/olidd_pkg.sv
rtl/olidd_if.sv
rtl/olidd_ram.sv
rtl/ordered_list_insert_delete_dump_core.sv
tb/sv/ordered_list_insert_delete_dump_core_test.sv
